@@ rtl/crc_framed_packet_decoder_macros.svh @@
// Assertion macros shared by the decoder RTL.
// Each takes a label, a triggering condition and the condition that must hold.
`ifndef CRC_FRAMED_PACKET_DECODER_MACROS_SVH
`define CRC_FRAMED_PACKET_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the trigger.
`define CFPD_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("decoder assertion failed");

// The consequent must hold in the cycle after the trigger.
`define CFPD_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("decoder assertion failed");

`else

`define CFPD_ASSERT_SAME(label, trig, cond)
`define CFPD_ASSERT_NEXT(label, trig, cond)

`endif

`endif

@@ rtl/cfpd_pkg.sv @@
`timescale 1ns / 1ps

package cfpd_pkg;

    // Frame sizes by type, and the size of the byte store.
    localparam int COMMAND_BYTES = 24;
    localparam int ACK_BYTES     = 18;
    localparam int STORE_DEPTH   = 24;
    localparam int COUNT_W       = 5;

    // Header bytes.
    localparam logic [7:0] MAGIC_0      = 8'h52;
    localparam logic [7:0] MAGIC_1      = 8'h45;
    localparam logic [7:0] VERSION      = 8'h01;
    localparam logic [7:0] TYPE_COMMAND = 8'h01;
    localparam logic [7:0] TYPE_ACK     = 8'h02;

    // CRC-16/CCITT-FALSE.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_HEADER   = 2'd1,
        ST_BAD_LENGTH   = 2'd2,
        ST_CRC_MISMATCH = 2'd3
    } t_status;

    // Input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // Result item.
    typedef struct packed {
        t_status     status;
        logic        frame_kind;
        logic [31:0] pair_id;
        logic [31:0] session_no;
        logic [15:0] sequence_res;
        logic [7:0]  code_or_state;
        logic [7:0]  flags_or_faults;
        logic [15:0] batt_mvolt;
        logic [31:0] powered_ms;
    } t_out_item;

endpackage

@@ rtl/crc_framed_packet_decoder.sv @@
`timescale 1ns / 1ps
// Frame decoder for fixed-size packets protected by CRC-16/CCITT-FALSE. Bytes
// are taken one per cycle unless the input stalls, and the whole per-byte
// update (header check, byte store, byte-wide CRC step) happens in the cycle in
// which the item is accepted. On the byte marked last, one result item is
// written to the output register and the frame state clears; other bytes give
// no result. The input stalls only while a result waits in the output register
// and the receiver is stalling, for as long as both hold.
// Failed frames return their status with every other field zero.

`include "crc_framed_packet_decoder_macros.svh"

module crc_framed_packet_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cfpd_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cfpd_pkg::t_out_item  o_out_data
);

    localparam logic [cfpd_pkg::COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [cfpd_pkg::COUNT_W-1:0] DEPTH_C =
        cfpd_pkg::COUNT_W'(cfpd_pkg::STORE_DEPTH);
    localparam logic [cfpd_pkg::COUNT_W-1:0] CMD_C =
        cfpd_pkg::COUNT_W'(cfpd_pkg::COMMAND_BYTES);
    localparam logic [cfpd_pkg::COUNT_W-1:0] ACK_C =
        cfpd_pkg::COUNT_W'(cfpd_pkg::ACK_BYTES);
    localparam logic [cfpd_pkg::COUNT_W-1:0] MIN_C = 5'd4;

    // One byte through the CRC, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ cfpd_pkg::CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    logic [cfpd_pkg::COUNT_W-1:0] r_count, n_count;
    logic [15:0]                  r_crc, r_crc_prev;
    logic                         r_header_bad, n_header_bad;
    logic                         r_kind, n_kind;
    logic [7:0]                   r_store [cfpd_pkg::STORE_DEPTH];
    logic                         r_out_valid;
    cfpd_pkg::t_out_item          r_out, n_out;

    logic        in_acc;
    logic [7:0]  crc_lo_byte;
    logic [15:0] crc_rx;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_out_valid && i_out_stall;

    // Header check on the first four bytes.
    always_comb begin
        n_header_bad = r_header_bad;
        n_kind       = r_kind;
        unique case (r_count)
            5'd0: if (i_in_data.data_byte != cfpd_pkg::MAGIC_0) n_header_bad = 1'b1;
            5'd1: if (i_in_data.data_byte != cfpd_pkg::MAGIC_1) n_header_bad = 1'b1;
            5'd2: if (i_in_data.data_byte != cfpd_pkg::VERSION) n_header_bad = 1'b1;
            5'd3: begin
                if (i_in_data.data_byte == cfpd_pkg::TYPE_ACK) begin
                    n_kind = 1'b1;
                end else if (i_in_data.data_byte != cfpd_pkg::TYPE_COMMAND) begin
                    n_header_bad = 1'b1;
                end
            end
            default: ;
        endcase
        n_count = (r_count < COUNT_MAX) ? r_count + 5'd1 : COUNT_MAX;
    end

    // Received CRC: low byte comes from the byte store, high byte is this one.
    assign crc_lo_byte = n_kind ? r_store[cfpd_pkg::ACK_BYTES-2]
                                : r_store[cfpd_pkg::COMMAND_BYTES-2];
    assign crc_rx      = {i_in_data.data_byte, crc_lo_byte};

    // Result for a frame that ends with this byte.
    always_comb begin
        n_out = '0;
        priority if (n_header_bad || n_count < MIN_C) begin
            n_out.status = cfpd_pkg::ST_BAD_HEADER;
        end else if (n_count != (n_kind ? ACK_C : CMD_C)) begin
            n_out.status = cfpd_pkg::ST_BAD_LENGTH;
        end else if (r_crc_prev != crc_rx) begin
            n_out.status = cfpd_pkg::ST_CRC_MISMATCH;
        end else begin
            n_out.status          = cfpd_pkg::ST_OK;
            n_out.frame_kind      = n_kind;
            n_out.pair_id         = {r_store[7], r_store[6], r_store[5], r_store[4]};
            n_out.session_no      = {r_store[11], r_store[10], r_store[9], r_store[8]};
            n_out.sequence_res    = {r_store[13], r_store[12]};
            n_out.code_or_state   = r_store[14];
            n_out.flags_or_faults = r_store[15];
            if (!n_kind) begin
                n_out.batt_mvolt = {r_store[17], r_store[16]};
                n_out.powered_ms = {r_store[21], r_store[20], r_store[19], r_store[18]};
            end
        end
    end

    // Frame state: cleared after the last byte of each frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_crc        <= cfpd_pkg::CRC_INIT;
            r_crc_prev   <= cfpd_pkg::CRC_INIT;
            r_header_bad <= 1'b0;
            r_kind       <= 1'b0;
        end else if (in_acc) begin
            if (i_in_data.last_byte) begin
                r_count      <= '0;
                r_crc        <= cfpd_pkg::CRC_INIT;
                r_crc_prev   <= cfpd_pkg::CRC_INIT;
                r_header_bad <= 1'b0;
                r_kind       <= 1'b0;
            end else begin
                r_count      <= n_count;
                r_crc        <= crc_byte(r_crc, i_in_data.data_byte);
                r_crc_prev   <= r_crc;
                r_header_bad <= n_header_bad;
                r_kind       <= n_kind;
            end
        end
    end

    // Byte store: the first bytes of the frame, at their positions.
    always_ff @(posedge i_clk) begin
        if (in_acc && r_count < DEPTH_C) begin
            r_store[r_count] <= i_in_data.data_byte;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && i_in_data.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.last_byte) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks.
    `CFPD_ASSERT_NEXT(a_clear_after_last, in_acc && i_in_data.last_byte, r_count == '0)
    `CFPD_ASSERT_SAME(a_stall_only_full, o_in_stall, r_out_valid)
    `CFPD_ASSERT_SAME(a_fail_fields_zero, r_out_valid && r_out.status != cfpd_pkg::ST_OK,
                      r_out.pair_id == '0 && r_out.frame_kind == 1'b0)
    `CFPD_ASSERT_SAME(a_ack_no_uptime, r_out_valid && r_out.frame_kind,
                      r_out.powered_ms == '0 && r_out.batt_mvolt == '0)

endmodule
